[rtl/core/assert_macros.svh]
// Assertion macros shared by the radius mean filter RTL.
// Uses the clock clk and the active-low reset arst_n of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_AR(lbl, prop, msg)
`define ASSERT_NR(lbl, prop, msg)
`endif
`endif

[rtl/core/rmit_pkg.sv]
// Package for the radius mean intensity threshold core: widths, codes, types.
// No dependencies.
`default_nettype none
package rmit_pkg;
	localparam int MAX_POINTS = 4096;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int COORD_W    = 18;
	localparam int INT_W      = 8;
	localparam int ENTRY_W    = 3 * COORD_W + INT_W;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int RAD_W      = 38;
	localparam int THR_W      = 8;
	localparam int SUM_W      = CNT_W + INT_W;
	localparam int DVD_W      = SUM_W + 8;
	localparam int STEP_W     = $clog2(DVD_W + 1);
	localparam int MEAN_W     = 16;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_RADIUS_SQ = 1'd0;
	localparam cfg_idx_t CFG_THRESHOLD = 1'd1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NOT_LOADED = 2'd1,
		STAT_FULL       = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REF,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV,
		ST_FINISH
	} state_t;
endpackage
`default_nettype wire

[rtl/core/rmit_if.sv]
// Request and response channel interfaces for the radius mean filter core.
// Depends on rmit_pkg.
`default_nettype none
interface rmit_req_if;
	import rmit_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [1:0]                opcode;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic [INT_W-1:0]          raw_intensity;
	logic [ADDR_W-1:0]         query_index;
	modport source (output valid, opcode, pos_x, pos_y, pos_z, raw_intensity, query_index,
		input ready);
	modport sink (input valid, opcode, pos_x, pos_y, pos_z, raw_intensity, query_index,
		output ready);
endinterface

interface rmit_rsp_if;
	import rmit_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ADDR_W-1:0] result_index;
	logic [CNT_W-1:0]  neighbour_count;
	logic [MEAN_W-1:0] mean_q8;
	logic              kept;
	modport source (output valid, status, result_index, neighbour_count, mean_q8, kept,
		input ready);
	modport sink (input valid, status, result_index, neighbour_count, mean_q8, kept,
		output ready);
endinterface
`default_nettype wire

[rtl/core/rmit_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module rmit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

[rtl/core/radius_mean_intensity_threshold_core.sv]
// Radius mean intensity threshold core: point store, exhaustive scan, divider.
// Depends on rmit_pkg, rmit_req_if/rmit_rsp_if, rmit_ram and assert_macros.svh.
//
// Usage:
//   req carries one request at a time: clear, load point, or query point.
//   rsp returns exactly one response per request, in order.
//   cfg_we/cfg_index/cfg_data write radius_sq (index 0) or threshold (index 1);
//   write only while no request is in flight.
// Sequencing:
//   Clear, load, failed query and unknown opcode pass from accept through
//   the finish state into the output register.
//   Successful query: the scan reads one store entry per cycle, then a
//   restoring divider takes one quotient bit per cycle for the mean.
// Throughput: one request in flight; req.ready is high only while idle.
//   A finished response sits in an output register, so the next request
//   is accepted while it waits.
// Reset: store count cleared, radius_sq = 1000000, threshold = 5. Store
//   contents need no clearing. A stalled rsp holds its payload; a further
//   response waits in the finish state until the register frees.
`default_nettype none
`include "assert_macros.svh"
module radius_mean_intensity_threshold_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	rmit_req_if.sink                           req,
	rmit_rsp_if.source                         rsp,
	input  wire logic                          cfg_we,
	input  wire rmit_pkg::cfg_idx_t            cfg_index,
	input  wire logic [rmit_pkg::RAD_W-1:0]    cfg_data
);
	import rmit_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  point_cnt_q;
	logic [RAD_W-1:0]  radius_sq_q;
	logic [THR_W-1:0]  threshold_q;

	status_t           status_q;
	logic [ADDR_W-1:0] ridx_q;
	logic              qry_ok_q;

	logic [ADDR_W-1:0] k_q;
	logic signed [COORD_W-1:0] ref_x_q, ref_y_q, ref_z_q;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               issue;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [COORD_W-1:0] dx_s2, dy_s2, dz_s2;
	logic [INT_W-1:0]   int_s2, int_s3, int_s4;
	logic [SQ_W-1:0]    sqx_s3, sqy_s3, sqz_s3;
	logic               hit_s4;

	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              kept_q;

	logic              out_vld_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_idx_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [MEAN_W-1:0] out_mean_q;
	logic              out_kept_q;

	logic              accept;
	logic              full;
	logic              q_valid;
	logic              scan_last;
	logic              pipe_empty;
	logic              out_load;
	logic [SUM_W-1:0]  thr_cnt;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_sub;
	logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;
	logic [INT_W-1:0]  rd_i;
	logic signed [COORD_W:0] ddx, ddy, ddz;
	logic [RAD_W-1:0]  dist_sum;

	assign accept     = req.valid && req.ready;
	assign full       = (point_cnt_q == CNT_W'(MAX_POINTS));
	assign q_valid    = ({1'b0, req.query_index} < point_cnt_q);
	assign scan_last  = ({1'b0, k_q} == point_cnt_q - CNT_W'(1));
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3 && !v_s4;
	assign out_load   = (state_q == ST_FINISH) && (!out_vld_q || rsp.ready);
	assign thr_cnt    = SUM_W'(threshold_q) * SUM_W'(cnt_q);
	assign rem_sh     = {rem_q, dvd_q[DVD_W-1]};
	assign rem_sub    = rem_sh - {1'b0, cnt_q};

	assign rd_x = ram_rdata[ENTRY_W-1 -: COORD_W];
	assign rd_y = ram_rdata[ENTRY_W-COORD_W-1 -: COORD_W];
	assign rd_z = ram_rdata[INT_W+COORD_W-1 -: COORD_W];
	assign rd_i = ram_rdata[INT_W-1:0];
	assign ddx  = {rd_x[COORD_W-1], rd_x} - {ref_x_q[COORD_W-1], ref_x_q};
	assign ddy  = {rd_y[COORD_W-1], rd_y} - {ref_y_q[COORD_W-1], ref_y_q};
	assign ddz  = {rd_z[COORD_W-1], rd_z} - {ref_z_q[COORD_W-1], ref_z_q};
	assign dist_sum = RAD_W'(sqx_s3) + RAD_W'(sqy_s3) + RAD_W'(sqz_s3);

	rmit_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = k_q;
		ram_wdata = {req.pos_x, req.pos_y, req.pos_z, req.raw_intensity};
		issue     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_FINISH;
					case (opcode_t'(req.opcode))
						OP_LOAD: begin
							ram_addr = point_cnt_q[ADDR_W-1:0];
							ram_we   = !full;
						end
						OP_QUERY: begin
							ram_addr = req.query_index;
							if (q_valid) begin
								state_d = ST_REF;
							end
						end
						default: ;
					endcase
				end
			end
			ST_REF: begin
				ram_addr = '0;
				issue    = 1'b1;
				state_d  = (point_cnt_q == CNT_W'(1)) ? ST_DRAIN : ST_SCAN;
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pipe_empty) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(DVD_W - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_cnt_q <= '0;
			radius_sq_q <= RAD_W'(1000000);
			threshold_q <= THR_W'(5);
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RADIUS_SQ: radius_sq_q <= cfg_data;
					CFG_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				case (opcode_t'(req.opcode))
					OP_CLEAR: point_cnt_q <= '0;
					OP_LOAD: begin
						if (!full) begin
							point_cnt_q <= point_cnt_q + CNT_W'(1);
						end
					end
					default: ;
				endcase
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= STAT_OK;
			ridx_q   <= '0;
			qry_ok_q <= 1'b0;
			cnt_q    <= '0;
			sum_q    <= '0;
			case (opcode_t'(req.opcode))
				OP_LOAD: begin
					if (full) begin
						status_q <= STAT_FULL;
					end else begin
						ridx_q <= point_cnt_q[ADDR_W-1:0];
					end
				end
				OP_QUERY: begin
					ridx_q   <= req.query_index;
					qry_ok_q <= q_valid;
					if (!q_valid) begin
						status_q <= STAT_NOT_LOADED;
					end
				end
				default: ;
			endcase
		end
		if (state_q == ST_REF) begin
			ref_x_q <= rd_x;
			ref_y_q <= rd_y;
			ref_z_q <= rd_z;
			k_q     <= ADDR_W'(1);
		end else if (issue) begin
			k_q <= k_q + ADDR_W'(1);
		end

		dx_s2  <= ddx[COORD_W] ? COORD_W'(-ddx) : ddx[COORD_W-1:0];
		dy_s2  <= ddy[COORD_W] ? COORD_W'(-ddy) : ddy[COORD_W-1:0];
		dz_s2  <= ddz[COORD_W] ? COORD_W'(-ddz) : ddz[COORD_W-1:0];
		int_s2 <= rd_i;
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
		sqz_s3 <= SQ_W'(dz_s2) * SQ_W'(dz_s2);
		int_s3 <= int_s2;
		hit_s4 <= (dist_sum <= radius_sq_q);
		int_s4 <= int_s3;
		if (v_s4 && hit_s4) begin
			cnt_q <= cnt_q + CNT_W'(1);
			sum_q <= sum_q + SUM_W'(int_s4);
		end

		if (state_q == ST_DRAIN && pipe_empty) begin
			dvd_q  <= {sum_q, 8'd0};
			rem_q  <= '0;
			step_q <= '0;
			kept_q <= (sum_q > thr_cnt);
		end else if (state_q == ST_DIV) begin
			step_q <= step_q + STEP_W'(1);
			if (!rem_sub[CNT_W]) begin
				rem_q <= rem_sub[CNT_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CNT_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			end
		end

		if (out_load) begin
			out_status_q <= status_q;
			out_idx_q    <= ridx_q;
			out_cnt_q    <= qry_ok_q ? cnt_q : '0;
			out_mean_q   <= qry_ok_q ? dvd_q[MEAN_W-1:0] : '0;
			out_kept_q   <= qry_ok_q && kept_q;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.status          = out_status_q;
	assign rsp.result_index    = out_idx_q;
	assign rsp.neighbour_count = out_cnt_q;
	assign rsp.mean_q8         = out_mean_q;
	assign rsp.kept            = out_kept_q;

	`ASSERT_AR(a_cnt_bound, point_cnt_q <= CNT_W'(MAX_POINTS), "point count past store depth")
	`ASSERT_AR(a_pipe_scope, v_s4 |-> (state_q == ST_SCAN || state_q == ST_DRAIN), "scan data outside scan")
	`ASSERT_AR(a_rem_bound, (state_q == ST_DIV) |-> (rem_q < cnt_q), "divider remainder not below divisor")
	`ASSERT_AR(a_query_start, (accept && req.opcode == OP_QUERY && q_valid) |=> (state_q == ST_REF), "valid query did not start scan")
endmodule
`default_nettype wire
